@@ design/crc_checked_frame_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// crc checked frame decoder assertion macros
// shared helpers for the concurrent checks on the decoder ports
// ----------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_DECODER_MACROS_SVH
`define CRC_CHECKED_FRAME_DECODER_MACROS_SVH

// property sampled on the rising clock, off during reset
`define CCFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must hold whenever the trigger holds
`define CCFD_ASSERT_IMPLY(lbl, clk, rst, trig, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

`endif

@@ design/ccfd_pkg.sv @@
// ----------------------------------------------------------------------------
// ccfd_pkg
// types, codes and the byte-wide crc-16 step for the frame decoder
// ----------------------------------------------------------------------------
package ccfd_pkg;

   localparam int unsigned MAX_DATA_DEFAULT = 1024;
   localparam int unsigned FRAME_OVERHEAD   = 10;
   localparam int unsigned DELAY_DEPTH      = 6;
   localparam int unsigned OUT_DEPTH        = 4;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_LENGTH   = 2'd1,
      STATUS_CRC      = 2'd2,
      STATUS_RESERVED = 2'd3
   } ccfd_status_type;

   typedef struct packed {
      logic            kind;
      logic [7:0]      data_byte;
      logic [15:0]     command;
      logic [10:0]     payload_count;
      ccfd_status_type status;
      logic            last;
   } ccfd_result_type;

   // up to two results from one request, slot0 first
   typedef struct packed {
      logic [1:0]      count;
      ccfd_result_type slot0;
      ccfd_result_type slot1;
   } ccfd_push_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  din);
      logic [15:0] c;
      c = crc ^ {din, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ design/ccfd_out_fifo.sv @@
// ----------------------------------------------------------------------------
// ccfd_out_fifo
// small result queue, takes up to two results a cycle, gives one on out_ready
// ----------------------------------------------------------------------------
module ccfd_out_fifo import ccfd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ccfd_push_type   push,
   output logic            space_two,
   output logic            out_valid,
   input  logic            out_ready,
   output ccfd_result_type out_result
);

   localparam int unsigned PW = $clog2(OUT_DEPTH);

   ccfd_result_type entries_ff [OUT_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     level_ff, level_in;
   logic            pop;
   logic [PW-1:0]   wr_next;

   assign out_valid  = (level_ff != '0);
   assign out_result = entries_ff[rd_ptr_ff];
   assign space_two  = (level_ff <= (PW+1)'(OUT_DEPTH - 2));
   assign pop        = out_valid & out_ready;
   assign wr_next    = wr_ptr_ff + PW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push.count);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      level_in  = level_ff + (PW+1)'(push.count) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.slot0;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.slot1;
      end
   end

endmodule

@@ design/ccfd_core.sv @@
// ----------------------------------------------------------------------------
// ccfd_core
// per-byte frame state: header capture, crc, trailer delay line, status
// ----------------------------------------------------------------------------
module ccfd_core import ccfd_pkg::*; #(
   parameter int unsigned MAX_DATA = MAX_DATA_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    wire_byte,
   input  logic          frame_end,
   output ccfd_push_type push
);

   localparam int unsigned LIMIT = MAX_DATA + FRAME_OVERHEAD;
   localparam int unsigned CW    = $clog2(LIMIT + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    delay_ff [DELAY_DEPTH];
   logic [7:0]    delay_in [DELAY_DEPTH];
   logic [15:0]   command_ff, command_in;
   logic [15:0]   length_ff, length_in;
   logic          overflow_ff, overflow_in;

   logic            emit;
   logic [15:0]     len16;
   logic [15:0]     recv_crc;
   logic            resv_nz;
   ccfd_result_type data_res;
   ccfd_result_type stat_res;

   always_comb begin
      count_in    = count_ff;
      crc_in      = crc_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      overflow_in = overflow_ff;
      for (int i = 0; i < DELAY_DEPTH; i++) begin
         delay_in[i] = delay_ff[i];
      end

      emit = (count_ff >= CW'(FRAME_OVERHEAD));

      // advance state with this byte
      if (count_ff >= CW'(2)) begin
         crc_in = crc16_byte(crc_ff, delay_ff[DELAY_DEPTH-2]);
      end
      for (int i = 0; i < DELAY_DEPTH - 1; i++) begin
         delay_in[i] = delay_ff[i+1];
      end
      delay_in[DELAY_DEPTH-1] = wire_byte;

      if (count_ff == CW'(0)) begin
         command_in = {wire_byte, 8'h00};
      end else if (count_ff == CW'(1)) begin
         command_in = {command_ff[15:8], wire_byte};
      end else if (count_ff == CW'(2)) begin
         length_in = {wire_byte, 8'h00};
      end else if (count_ff == CW'(3)) begin
         length_in = {length_ff[15:8], wire_byte};
      end

      if (count_ff >= CW'(LIMIT)) begin
         overflow_in = 1'b1;
      end else begin
         count_in = count_ff + CW'(1);
      end

      // end of frame checks
      len16    = 16'(count_in);
      recv_crc = {delay_in[DELAY_DEPTH-2], delay_in[DELAY_DEPTH-1]};
      resv_nz  = (delay_in[0] | delay_in[1] | delay_in[2] | delay_in[3]) != 8'h00;

      stat_res             = '0;
      stat_res.kind        = KIND_STATUS;
      stat_res.command     = command_in;
      stat_res.last        = 1'b1;
      if (overflow_in || (len16 < 16'(FRAME_OVERHEAD)) || (len16 > 16'(LIMIT)) ||
          (length_in != len16)) begin
         stat_res.status = STATUS_LENGTH;
      end else begin
         stat_res.payload_count = 11'(len16 - 16'(FRAME_OVERHEAD));
         if (recv_crc != crc_in) begin
            stat_res.status = STATUS_CRC;
         end else if (resv_nz) begin
            stat_res.status = STATUS_RESERVED;
         end else begin
            stat_res.status = STATUS_OK;
         end
      end

      data_res           = '0;
      data_res.kind      = KIND_DATA;
      data_res.data_byte = delay_ff[0];

      push = '0;
      if (accept) begin
         if (emit) begin
            push.slot0 = data_res;
            push.slot1 = stat_res;
            push.count = frame_end ? 2'd2 : 2'd1;
         end else if (frame_end) begin
            push.slot0 = stat_res;
            push.count = 2'd1;
         end
      end

      // frame closed, back to idle values
      if (frame_end) begin
         count_in    = '0;
         crc_in      = CRC_INIT;
         command_in  = '0;
         length_in   = '0;
         overflow_in = 1'b0;
         for (int i = 0; i < DELAY_DEPTH; i++) begin
            delay_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         crc_ff      <= CRC_INIT;
         command_ff  <= '0;
         length_ff   <= '0;
         overflow_ff <= 1'b0;
         for (int i = 0; i < DELAY_DEPTH; i++) begin
            delay_ff[i] <= '0;
         end
      end else if (accept) begin
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         command_ff  <= command_in;
         length_ff   <= length_in;
         overflow_ff <= overflow_in;
         for (int i = 0; i < DELAY_DEPTH; i++) begin
            delay_ff[i] <= delay_in[i];
         end
      end
   end

endmodule

@@ design/crc_checked_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// crc_checked_frame_decoder
// length-prefixed frame decoder with crc-16/ccitt-false check
// ----------------------------------------------------------------------------
// req channel: one wire byte per request, req_frame_end on the final byte.
// rsp channel: kind 0 is a tentative payload byte, kind 1 the status that
// closes the frame (command, payload length, status code, last set).
// payload bytes trail the wire by six requests, so the reserved word and
// the crc never show up as payload; drop the payload on a bad status.
// results of a request are registered into the result queue.
// throughput: one request per cycle while req_ready is high; a frame end
// that also releases a payload byte pushes two results to the single-pop queue.
// req_ready stays high while the four-entry result queue has room for two,
// so a stalled receiver backs up the request side.
// reset clears the frame state and empties the result queue; no frame is
// in progress afterwards.
// ----------------------------------------------------------------------------
module crc_checked_frame_decoder import ccfd_pkg::*; #(
   parameter int unsigned MAX_DATA = MAX_DATA_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_wire_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_command,
   output logic [10:0] rsp_payload_count,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   logic            accept;
   ccfd_push_type   push;
   ccfd_result_type out_result;

   assign accept = req_valid & req_ready;

   ccfd_core #(
      .MAX_DATA (MAX_DATA)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .wire_byte (req_wire_byte),
      .frame_end (req_frame_end),
      .push      (push)
   );

   ccfd_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space_two  (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (out_result)
   );

   assign rsp_kind          = out_result.kind;
   assign rsp_data_byte     = out_result.data_byte;
   assign rsp_command       = out_result.command;
   assign rsp_payload_count = out_result.payload_count;
   assign rsp_status        = out_result.status;
   assign rsp_last          = out_result.last;

endmodule

@@ design/ccfd_checker.sv @@
// ----------------------------------------------------------------------------
// ccfd_checker
// port-level checks on the frame decoder result channel
// ----------------------------------------------------------------------------
`include "crc_checked_frame_decoder_macros.svh"

module ccfd_checker import ccfd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [15:0] rsp_command,
   input logic [10:0] rsp_payload_count,
   input logic [1:0]  rsp_status,
   input logic        rsp_last
);

   logic        show_data;
   logic        data_clean;
   logic        show_status;
   logic        status_clean;
   logic        length_bad;
   logic        no_count;
   logic        rsp_stalled;
   logic        rsp_same;
   logic [38:0] rsp_word;
   logic [38:0] word_ff;

   assign show_data    = rsp_valid && (rsp_kind == KIND_DATA);
   assign data_clean   = !rsp_last && (rsp_command == 16'h0000) &&
                         (rsp_payload_count == 11'd0) && (rsp_status == STATUS_OK);
   assign show_status  = rsp_valid && (rsp_kind == KIND_STATUS);
   assign status_clean = rsp_last && (rsp_data_byte == 8'h00);
   assign length_bad   = show_status && (rsp_status == STATUS_LENGTH);
   assign no_count     = (rsp_payload_count == 11'd0);
   assign rsp_stalled  = rsp_valid && !rsp_ready;
   assign rsp_word     = {rsp_kind, rsp_data_byte, rsp_command, rsp_payload_count,
                          rsp_status, rsp_last};
   assign rsp_same     = rsp_valid && (rsp_word == word_ff);

   always_ff @(posedge clock) begin
      word_ff <= rsp_word;
   end

   `CCFD_ASSERT_IMPLY(a_data, clock, reset, show_data, data_clean, "payload with status fields")
   `CCFD_ASSERT_IMPLY(a_status, clock, reset, show_status, status_clean, "malformed status")
   `CCFD_ASSERT_IMPLY(a_length_err, clock, reset, length_bad, no_count, "length error with count")
   `CCFD_ASSERT(a_rsp_hold, clock, reset, rsp_stalled |=> rsp_same, "stalled result changed")

endmodule

bind crc_checked_frame_decoder ccfd_checker u_ccfd_checker (.*);

@@ tb/crc_checked_frame_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// crc_checked_frame_decoder_tb
// self-checking bench: builds length-prefixed frames with crc-16/ccitt-false,
// some clean and some with a flaw, feeds them a byte per request under random
// idling on both channels, and compares every result against an internal
// model of the decoder that predicts payload bytes and the closing status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc_checked_frame_decoder_tb;
   import ccfd_pkg::*;

   localparam int unsigned FRAME_LIMIT = MAX_DATA_DEFAULT + FRAME_OVERHEAD;
   localparam int unsigned ITEM_TARGET = 1100;
   localparam int unsigned QUIET_TAIL  = 150;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef enum int {
      FLAW_NONE,
      FLAW_CRC,
      FLAW_RESERVED,
      FLAW_LENGTH
   } frame_flaw_type;

   class frame_checker_type;
      ccfd_result_type pending_results[$];
      logic [16:0]     frame_pos;
      logic [15:0]     crc_acc;
      logic [7:0]      held[6];
      logic [15:0]     cmd_word;
      logic [15:0]     decl_len;
      bit              overrun;
      int unsigned     mismatches;

      function new();
         mismatches = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         frame_pos = '0;
         crc_acc   = CRC_INIT;
         foreach (held[i]) held[i] = 8'h00;
         cmd_word  = '0;
         decl_len  = '0;
         overrun   = 1'b0;
      endfunction

      static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         logic        fb;
         c = crc;
         for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) c = c ^ CRC_POLY;
         end
         return c;
      endfunction

      function void predict_byte(logic [7:0] b, logic fe);
         ccfd_result_type r;
         logic [16:0]     pos;
         logic [7:0]      leaving;
         logic [15:0]     rx_crc;
         pos     = frame_pos;
         leaving = held[0];
         if (pos >= 2) crc_acc = crc_step(crc_acc, held[4]);
         if (pos >= FRAME_OVERHEAD) begin
            r             = '0;
            r.kind        = KIND_DATA;
            r.data_byte   = leaving;
            r.status      = STATUS_OK;
            pending_results.push_back(r);
         end
         for (int i = 0; i < 5; i++) held[i] = held[i + 1];
         held[5] = b;
         case (pos)
            17'd0: cmd_word = {b, 8'h00};
            17'd1: cmd_word = {cmd_word[15:8], b};
            17'd2: decl_len = {b, 8'h00};
            17'd3: decl_len = {decl_len[15:8], b};
            default: ;
         endcase
         if (pos >= FRAME_LIMIT) overrun = 1'b1;
         else frame_pos = pos + 17'd1;
         if (fe) begin
            r         = '0;
            r.kind    = KIND_STATUS;
            r.command = cmd_word;
            r.last    = 1'b1;
            rx_crc    = {held[4], held[5]};
            if (overrun || frame_pos < FRAME_OVERHEAD || frame_pos > FRAME_LIMIT ||
                {1'b0, decl_len} != frame_pos) begin
               r.status = STATUS_LENGTH;
            end else begin
               r.payload_count = 11'(frame_pos - FRAME_OVERHEAD);
               if (rx_crc != crc_acc) r.status = STATUS_CRC;
               else if ((held[0] | held[1] | held[2] | held[3]) != 8'h00)
                  r.status = STATUS_RESERVED;
               else r.status = STATUS_OK;
            end
            pending_results.push_back(r);
            clear_frame();
         end
      endfunction

      function void compare_result(ccfd_result_type got);
         ccfd_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected: kind %0b data %02h cmd %04h cnt %0d st %0d last %0b",
                        got.kind, got.data_byte, got.command, got.payload_count,
                        got.status, got.last);
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
             got.command !== want.command || got.payload_count !== want.payload_count ||
             got.status !== want.status || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch expected: kind %0b data %02h cmd %04h cnt %0d st %0d last %0b",
                        want.kind, want.data_byte, want.command, want.payload_count,
                        want.status, want.last);
               $display("         actual:   kind %0b data %02h cmd %04h cnt %0d st %0d last %0b",
                        got.kind, got.data_byte, got.command, got.payload_count,
                        got.status, got.last);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_wire_byte;
   logic        req_frame_end;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_command;
   logic [10:0] rsp_payload_count;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   frame_checker_type decoder_model = new();
   int unsigned  items_sent;
   int unsigned  cycle_count;
   int unsigned  stall_left;
   int unsigned  mode_cycles;
   bit           idle_allowed;
   bit           sender_gaps;
   bit           rsp_stall_mode;

   crc_checked_frame_decoder DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_wire_byte     (req_wire_byte),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_command       (rsp_command),
      .rsp_payload_count (rsp_payload_count),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      ccfd_result_type got;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got.kind          = rsp_kind;
         got.data_byte     = rsp_data_byte;
         got.command       = rsp_command;
         got.payload_count = rsp_payload_count;
         got.status        = ccfd_status_type'(rsp_status);
         got.last          = rsp_last;
         decoder_model.compare_result(got);
      end
   end

   // receiver stall bursts, mode reshuffled now and then
   always @(negedge clock) begin
      logic ready_next;
      mode_cycles++;
      if (mode_cycles >= 100) begin
         mode_cycles    = 0;
         rsp_stall_mode = ($urandom_range(0, 2) != 0);
      end
      if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else if (idle_allowed && rsp_stall_mode && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 5) - 1;
         ready_next = 1'b0;
      end else begin
         ready_next = 1'b1;
      end
      rsp_ready <= ready_next;
   end

   task automatic send_byte(input logic [7:0] b, input logic fe);
      @(negedge clock);
      if (idle_allowed && sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_wire_byte <= b;
      req_frame_end <= fe;
      do @(posedge clock); while (req_ready !== 1'b1);
      items_sent++;
      decoder_model.predict_byte(b, fe);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (decoder_model.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_frame(input int unsigned payload_len, input frame_flaw_type flaw,
                             input logic [15:0] cmd);
      logic [7:0]  wire_bytes[$];
      logic [15:0] decl;
      logic [15:0] crc;
      int unsigned total;
      total = payload_len + FRAME_OVERHEAD;
      decl  = 16'(total);
      if (flaw == FLAW_LENGTH) decl = decl ^ (16'd1 << $urandom_range(0, 15));
      wire_bytes.push_back(cmd[15:8]);
      wire_bytes.push_back(cmd[7:0]);
      wire_bytes.push_back(decl[15:8]);
      wire_bytes.push_back(decl[7:0]);
      for (int i = 0; i < payload_len; i++) wire_bytes.push_back(8'($urandom));
      for (int i = 0; i < 4; i++) wire_bytes.push_back(8'h00);
      if (flaw == FLAW_RESERVED) begin
         for (int i = 0; i < 4; i++)
            if ($urandom_range(0, 1) == 1) wire_bytes[4 + payload_len + i] = 8'($urandom);
         wire_bytes[4 + payload_len + $urandom_range(0, 3)] = 8'($urandom_range(1, 255));
      end
      crc = CRC_INIT;
      foreach (wire_bytes[i]) crc = frame_checker_type::crc_step(crc, wire_bytes[i]);
      if (flaw == FLAW_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
      wire_bytes.push_back(crc[15:8]);
      wire_bytes.push_back(crc[7:0]);
      foreach (wire_bytes[i]) send_byte(wire_bytes[i], i == wire_bytes.size() - 1);
   endtask

   task automatic send_noise(input int unsigned n);
      for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
   endtask

   initial begin
      int unsigned pick;
      int unsigned plen;
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_wire_byte  = 8'h00;
      req_frame_end  = 1'b0;
      rsp_ready      = 1'b0;
      items_sent     = 0;
      cycle_count    = 0;
      stall_left     = 0;
      mode_cycles    = 0;
      idle_allowed   = 1'b1;
      sender_gaps    = 1'b1;
      rsp_stall_mode = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // very short frame, then end on a payload byte, then reserved word set
      send_byte(8'hFF, 1'b1);
      send_frame(1, FLAW_NONE, 16'hFFFF);
      send_frame(0, FLAW_RESERVED, 16'h0000);
      drain_results();

      while (items_sent < ITEM_TARGET) begin
         idle_allowed = (items_sent + QUIET_TAIL < ITEM_TARGET);
         sender_gaps  = ($urandom_range(0, 2) != 0);
         pick = $urandom_range(0, 99);
         plen = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60) : $urandom_range(0, 16);
         if (pick < 55) send_frame(plen, FLAW_NONE, 16'($urandom));
         else if (pick < 65) send_frame(plen, FLAW_CRC, 16'($urandom));
         else if (pick < 75) send_frame(plen, FLAW_RESERVED, 16'($urandom));
         else if (pick < 83) send_frame(plen, FLAW_LENGTH, 16'($urandom));
         else if (pick < 90) send_noise($urandom_range(1, 9));
         else send_noise($urandom_range(1, 40));
         if (idle_allowed && $urandom_range(0, 19) == 0) drain_results();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (decoder_model.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (decoder_model.mismatches == 0 && decoder_model.pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
